// ----- sv/ghp_pkg.sv -----
`timescale 1ns / 1ps

package ghp_pkg;

  // Item field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Default pool size (slots 1..N, slot 0 reserved)
  localparam int unsigned POOL_SLOTS_DEF = 64;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } op_e;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

// ----- sv/ghp_if.sv -----
`timescale 1ns / 1ps

// Request channel: operation and handle
interface ghp_in_if;
  logic                            valid;
  logic                            ready;
  logic [ghp_pkg::OP_W-1:0]        op;
  logic [ghp_pkg::HANDLE_W-1:0]    handle;

  modport source (output valid, output op, output handle, input ready);
  modport sink   (input valid, input op, input handle, output ready);
endinterface

// Result channel: handle, status and free slot count
interface ghp_out_if;
  logic                            valid;
  logic                            ready;
  logic [ghp_pkg::HANDLE_W-1:0]    handle_out;
  logic [ghp_pkg::STATUS_W-1:0]    status;
  logic [ghp_pkg::COUNT_W-1:0]     free_count;

  modport source (output valid, output handle_out, output status, output free_count,
                  input ready);
  modport sink   (input valid, input handle_out, input status, input free_count,
                  output ready);
endinterface

// ----- sv/generational_handle_pool.sv -----
`timescale 1ns / 1ps

// Generational handle allocator for slots 1..POOL_SLOTS (slot 0 is never handed
// out). A handle is generation << 16 | slot. Allocate pops the top free slot,
// bumps its 16-bit generation (skipping zero) and marks it live; release checks
// range, live mark and generation, then frees the slot; check only validates.
// On acceptance the slot's generation/live entry (and, on allocate, the next
// free-stack entry) is read from RAM; in execute it is updated and written
// back. The next item is accepted only once execute is left, and a result
// waiting in the output register stalls execute. No clearing pass is needed
// after reset: a low-water mark on the free stack tells which stack entries
// and which slots were never written.
module generational_handle_pool #(
  parameter int unsigned POOL_SLOTS = ghp_pkg::POOL_SLOTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ghp_in_if.sink   in_i,
  ghp_out_if.source out_o
);

  localparam int unsigned DW  = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SAW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned XW  = ghp_pkg::SLOT_W + 1;
  localparam int unsigned GW  = ghp_pkg::GEN_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  logic [DW-1:0] depth_q, depth_d;   // free slots on the stack
  logic [DW-1:0] low_q, low_d;       // lowest depth ever reached
  logic [DW-1:0] top_q, top_d;       // slot on top of the stack

  ghp_pkg::op_e                  op_q;
  logic [ghp_pkg::HANDLE_W-1:0]  handle_q;

  logic                          out_valid_q;
  logic [ghp_pkg::HANDLE_W-1:0]  out_handle_q;
  logic [ghp_pkg::STATUS_W-1:0]  out_status_q;
  logic [ghp_pkg::COUNT_W-1:0]   out_count_q;

  logic accept, adv;

  // RAM ports
  logic            stk_re, stk_we;
  logic [SAW-1:0]  stk_raddr, stk_waddr;
  logic [DW-1:0]   stk_wdata, stk_rdata;
  logic            gen_re, gen_we;
  logic [DW-1:0]   gen_raddr, gen_waddr;
  logic [GW:0]     gen_wdata, gen_rdata;

  // Execute-stage decode
  logic [ghp_pkg::SLOT_W-1:0] hslot;
  logic [GW-1:0]              hgen;
  logic                       in_range;
  logic [XW-1:0]              gslot;
  logic                       touched;
  logic                       eff_live;
  logic [GW-1:0]              eff_gen;
  logic [GW-1:0]              new_gen;
  logic [DW-1:0]              sidx;
  logic                       valid_h;

  logic [ghp_pkg::HANDLE_W-1:0] res_handle;
  logic [ghp_pkg::STATUS_W-1:0] res_status;

  assign accept = in_i.valid && in_i.ready;
  assign adv    = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (state_q == S_IDLE);

  // Read issue on acceptance
  always_comb begin
    stk_re    = accept && (in_i.op == ghp_pkg::OP_ALLOC) && (depth_q >= DW'(2));
    stk_raddr = SAW'(depth_q - DW'(2));
    gen_re    = accept;
    if (in_i.op == ghp_pkg::OP_ALLOC) begin
      gen_raddr = top_q;
    end else begin
      gen_raddr = DW'(in_i.handle[ghp_pkg::SLOT_W-1:0]);
    end
  end

  // Decode of the item in execute
  assign hslot    = handle_q[ghp_pkg::SLOT_W-1:0];
  assign hgen     = handle_q[ghp_pkg::HANDLE_W-1:ghp_pkg::SLOT_W];
  assign in_range = (hslot != '0) && (XW'(hslot) <= XW'(POOL_SLOTS));
  assign gslot    = (op_q == ghp_pkg::OP_ALLOC) ? XW'(top_q) : XW'(hslot);
  // Slots above the number ever allocated still hold their reset entry
  assign touched  = gslot <= XW'(DW'(POOL_SLOTS) - low_q);
  assign eff_live = touched && gen_rdata[GW];
  assign eff_gen  = touched ? gen_rdata[GW-1:0] : '0;
  assign sidx     = depth_q - DW'(2);
  assign valid_h  = in_range && eff_live && (eff_gen == hgen);

  always_comb begin
    new_gen = eff_gen + GW'(1);
    if (new_gen == '0) begin
      new_gen = GW'(1);
    end
  end

  // Update and result
  always_comb begin
    depth_d    = depth_q;
    low_d      = low_q;
    top_d      = top_q;
    stk_we     = 1'b0;
    stk_waddr  = SAW'(depth_q);
    stk_wdata  = DW'(hslot);
    gen_we     = 1'b0;
    gen_waddr  = DW'(hslot);
    gen_wdata  = {1'b0, eff_gen};
    res_handle = '0;
    res_status = ghp_pkg::ST_INVALID;
    unique case (op_q)
      ghp_pkg::OP_ALLOC: begin
        if (depth_q == '0) begin
          res_status = ghp_pkg::ST_EMPTY;
        end else begin
          gen_we     = adv;
          gen_waddr  = top_q;
          gen_wdata  = {1'b1, new_gen};
          res_handle = {new_gen, ghp_pkg::SLOT_W'(top_q)};
          res_status = ghp_pkg::ST_OK;
          depth_d    = depth_q - DW'(1);
          if (depth_d < low_q) begin
            low_d = depth_d;
          end
          // Entries below the low-water mark were never written
          if (depth_q >= DW'(2)) begin
            top_d = (sidx < low_q) ? (DW'(POOL_SLOTS) - sidx) : stk_rdata;
          end
        end
      end
      ghp_pkg::OP_RELEASE: begin
        if (valid_h && (depth_q < DW'(POOL_SLOTS))) begin
          gen_we     = adv;
          stk_we     = adv;
          res_handle = handle_q;
          res_status = ghp_pkg::ST_OK;
          depth_d    = depth_q + DW'(1);
          top_d      = DW'(hslot);
        end
      end
      ghp_pkg::OP_CHECK: begin
        if (valid_h) begin
          res_handle = handle_q;
          res_status = ghp_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (adv)    state_d = S_IDLE;
      default:            state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= DW'(POOL_SLOTS);
      low_q       <= DW'(POOL_SLOTS);
      top_q       <= DW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        depth_q <= depth_d;
        low_q   <= low_d;
        top_q   <= top_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= ghp_pkg::op_e'(in_i.op);
      handle_q <= in_i.handle;
    end
    if (adv) begin
      out_handle_q <= res_handle;
      out_status_q <= res_status;
      out_count_q  <= ghp_pkg::COUNT_W'(depth_d);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.handle_out = out_handle_q;
  assign out_o.status     = out_status_q;
  assign out_o.free_count = out_count_q;

  // Free-slot stack
  ghp_ram #(
    .WIDTH (DW),
    .DEPTH (POOL_SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Per-slot live mark and generation
  ghp_ram #(
    .WIDTH (GW + 1),
    .DEPTH (POOL_SLOTS + 1)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (gen_re),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

endmodule

// ----- sv/ghp_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data
module ghp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- verif/tb_generational_handle_pool.sv -----
`timescale 1ns / 1ps

module tb_generational_handle_pool;
  import ghp_pkg::*;

  localparam int unsigned POOL = POOL_SLOTS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Result of one pool operation, as seen on the result channel
  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
  } pool_reply_t;

  // One row of the directed table; typed rows carry their own expected reply
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic                typed;
    pool_reply_t         reply;
  } stim_row_t;

  typedef enum logic [1:0] {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIXED
  } traffic_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  ghp_in_if  req_if ();
  ghp_out_if rsp_if ();

  generational_handle_pool #(
    .POOL_SLOTS(POOL)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // Shadow copy of the allocator state
  logic [SLOT_W-1:0] free_slots [POOL];
  int unsigned       free_depth;
  logic [GEN_W-1:0]  slot_gen   [POOL+1];
  logic              slot_live  [POOL+1];

  pool_reply_t replies_due [$];
  pool_reply_t typed_reply;
  pool_reply_t predicted;
  pool_reply_t due;
  logic        reply_is_typed;
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  stim_row_t   directed_rows [$];

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void reset_pool_shadow();
    for (int unsigned i = 0; i < POOL; i++) free_slots[i] = SLOT_W'(POOL - i);
    for (int unsigned i = 0; i <= POOL; i++) begin
      slot_gen[i]  = '0;
      slot_live[i] = 1'b0;
    end
    free_depth = POOL;
  endfunction

  // Apply one operation to the shadow state and return the reply it gives
  function automatic pool_reply_t predict_pool_op(logic [OP_W-1:0] op,
                                                  logic [HANDLE_W-1:0] handle);
    pool_reply_t r;
    int unsigned s;
    logic [GEN_W-1:0] g;
    logic valid_handle;
    r.handle_out = '0;
    r.status     = ST_INVALID;
    s = 32'(handle[SLOT_W-1:0]);
    g = handle[HANDLE_W-1:SLOT_W];
    valid_handle = (s != 0) && (s <= POOL) && slot_live[s] && (slot_gen[s] == g);
    case (op)
      OP_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_depth--;
          s = free_slots[free_depth];
          g = slot_gen[s] + 1'b1;
          if (g == '0) g = GEN_W'(1);
          slot_gen[s]  = g;
          slot_live[s] = 1'b1;
          r.handle_out = {g, SLOT_W'(s)};
          r.status     = ST_OK;
        end
      end
      OP_RELEASE: begin
        if (valid_handle && free_depth < POOL) begin
          slot_live[s] = 1'b0;
          free_slots[free_depth] = SLOT_W'(s);
          free_depth++;
          r.handle_out = handle;
          r.status     = ST_OK;
        end
      end
      OP_CHECK: begin
        if (valid_handle) begin
          r.handle_out = handle;
          r.status     = ST_OK;
        end
      end
      default: ;
    endcase
    r.free_count = COUNT_W'(free_depth);
    return r;
  endfunction

  // Result checking, then prediction of the item taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected item: handle_out %h status %0d free_count %0d",
                 rsp_if.handle_out, rsp_if.status, rsp_if.free_count);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (rsp_if.handle_out !== due.handle_out) begin
            $error("handle_out: expected %h, got %h", due.handle_out, rsp_if.handle_out);
            mismatches++;
          end
          if (rsp_if.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_if.status);
            mismatches++;
          end
          if (rsp_if.free_count !== due.free_count) begin
            $error("free_count: expected %0d, got %0d", due.free_count, rsp_if.free_count);
            mismatches++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        predicted = predict_pool_op(req_if.op, req_if.handle);
        replies_due.push_back(reply_is_typed ? typed_reply : predicted);
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic stim_row_t stim_row(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                                         logic typed, logic [HANDLE_W-1:0] h_out,
                                         logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.op               = op;
    row.handle           = handle;
    row.typed            = typed;
    row.reply.handle_out = h_out;
    row.reply.status     = st;
    row.reply.free_count = cnt;
    return row;
  endfunction

  function automatic int unsigned pick_live_slot();
    int unsigned live_list [$];
    for (int unsigned s = 1; s <= POOL; s++) if (slot_live[s]) live_list.push_back(s);
    if (live_list.size() == 0) return 0;
    return live_list[$urandom_range(live_list.size() - 1)];
  endfunction

  // Present one item, with random gaps before it; returns on the falling
  // edge after it is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                           input logic typed = 1'b0, input pool_reply_t reply = '0);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.handle  <= handle;
    reply_is_typed = typed;
    typed_reply    = reply;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One random item, mostly well formed handles taken from the shadow state
  task automatic send_random_item(input traffic_e mode);
    int unsigned pick;
    int unsigned alloc_w;
    int unsigned rel_w;
    int unsigned chk_w;
    int unsigned s;
    logic [GEN_W-1:0] g;
    logic [OP_W-1:0] op;
    case (mode)
      TRAFFIC_FILL: begin
        alloc_w = 88; rel_w = 2; chk_w = 5;
      end
      TRAFFIC_DRAIN: begin
        alloc_w = 2; rel_w = 88; chk_w = 5;
      end
      default: begin
        alloc_w = 35; rel_w = 30; chk_w = 15;
      end
    endcase
    pick = $urandom_range(99);
    s    = pick_live_slot();
    op   = $urandom_range(1) ? OP_RELEASE : OP_CHECK;
    if (pick < alloc_w || (s == 0 && pick < alloc_w + rel_w + chk_w)) begin
      send_item(OP_ALLOC, $urandom());
    end else if (pick < alloc_w + rel_w) begin
      send_item(OP_RELEASE, {slot_gen[s], SLOT_W'(s)});
    end else if (pick < alloc_w + rel_w + chk_w) begin
      send_item(OP_CHECK, {slot_gen[s], SLOT_W'(s)});
    end else begin
      case ($urandom_range(4))
        0: begin
          // current or stale generation of a random slot, which may not be live
          s = $urandom_range(1, POOL);
          g = slot_gen[s] - GEN_W'($urandom_range(2));
          send_item(op, {g, SLOT_W'(s)});
        end
        1: begin
          // reserved slot or slot beyond the pool
          s = $urandom_range(1) ? 0 : $urandom_range(POOL + 1, 16'hFFFF);
          send_item(op, {GEN_W'($urandom()), SLOT_W'(s)});
        end
        2: send_item(op, $urandom());
        3: begin
          // generation zero never matches
          if (s == 0) s = $urandom_range(1, POOL);
          send_item(op, {GEN_W'(0), SLOT_W'(s)});
        end
        default: send_item(OP_UNUSED, $urandom());
      endcase
    end
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    traffic_e mode;
    sent = 0;
    while (sent < n_items) begin
      mode  = traffic_e'($urandom_range(2));
      burst = $urandom_range(8, 90);
      while (burst != 0 && sent < n_items) begin
        send_random_item(mode);
        sent++;
        burst--;
      end
    end
  endtask

  // Main sequence
  initial begin
    req_if.valid  = 1'b0;
    req_if.op     = OP_ALLOC;
    req_if.handle = '0;
    reply_is_typed = 1'b0;
    typed_reply    = '0;
    reset_pool_shadow();

    directed_rows = '{
      stim_row(OP_CHECK,   32'h0000_0000, 1'b1, 32'h0,          ST_INVALID, 7'd64),
      stim_row(OP_RELEASE, 32'h0001_0001, 1'b1, 32'h0,          ST_INVALID, 7'd64),
      stim_row(OP_ALLOC,   32'hFFFF_FFFF, 1'b1, 32'h0001_0001, ST_OK,      7'd63),
      stim_row(OP_CHECK,   32'h0001_0001, 1'b1, 32'h0001_0001, ST_OK,      7'd63),
      stim_row(OP_CHECK,   32'h0000_0001, 1'b1, 32'h0,          ST_INVALID, 7'd63),
      stim_row(OP_CHECK,   32'h0002_0001, 1'b1, 32'h0,          ST_INVALID, 7'd63),
      stim_row(OP_RELEASE, 32'h0001_0000, 1'b1, 32'h0,          ST_INVALID, 7'd63),
      stim_row(OP_RELEASE, 32'h0001_0041, 1'b1, 32'h0,          ST_INVALID, 7'd63),
      stim_row(OP_CHECK,   32'hFFFF_FFFF, 1'b1, 32'h0,          ST_INVALID, 7'd63),
      stim_row(OP_UNUSED,  32'h0001_0001, 1'b1, 32'h0,          ST_INVALID, 7'd63),
      stim_row(OP_RELEASE, 32'h0001_0001, 1'b1, 32'h0001_0001, ST_OK,      7'd64),
      stim_row(OP_RELEASE, 32'h0001_0001, 1'b1, 32'h0,          ST_INVALID, 7'd64),
      stim_row(OP_ALLOC,   32'h0000_0000, 1'b0, 32'h0,          ST_OK,      7'd0),
      stim_row(OP_ALLOC,   32'h0000_0000, 1'b0, 32'h0,          ST_OK,      7'd0),
      stim_row(OP_CHECK,   32'h0001_0002, 1'b0, 32'h0,          ST_OK,      7'd0),
      stim_row(OP_CHECK,   32'h0001_0001, 1'b0, 32'h0,          ST_OK,      7'd0),
      stim_row(OP_RELEASE, 32'h0002_0001, 1'b0, 32'h0,          ST_OK,      7'd0),
      stim_row(OP_RELEASE, 32'h0001_0002, 1'b0, 32'h0,          ST_OK,      7'd0),
      stim_row(OP_CHECK,   32'h0001_FFFF, 1'b1, 32'h0,          ST_INVALID, 7'd64)
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, then three rounds of random traffic
    src_idle_pct  = 22;
    sink_idle_pct = 79;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].handle,
                directed_rows[i].typed, directed_rows[i].reply);
    end
    run_traffic(650);

    src_idle_pct  = 79;
    sink_idle_pct = 22;
    run_traffic(650);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_traffic(650);
    req_if.valid <= 1'b0;

    // Drain outstanding replies
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
